### hdl/sah_pkg.sv
// shared types, register codes and widths for the split cost unit
// no dependencies; every other file imports this package
`default_nettype none

package sah_pkg;

    localparam int COUNT_BITS_DEF = 20;
    localparam int COORD_BITS_DEF = 32;

    localparam int COST_BITS      = 48;
    localparam int FRAC_BITS      = 16;
    localparam int TRAV_BITS      = 24;
    localparam int ICOST_BITS     = 24;
    localparam int BONUS_BITS     = 17;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int KCOST_BITS     = ICOST_BITS + FRAC_BITS;
    localparam int MUL_CHUNK      = 32;

    localparam logic [TRAV_BITS-1:0]  TRAV_RESET  = 24'h010000;
    localparam logic [ICOST_BITS-1:0] ICOST_RESET = 24'h010000;
    localparam logic [BONUS_BITS-1:0] BONUS_RESET = 17'h00000;
    localparam logic [BONUS_BITS-1:0] BONUS_ONE   = 17'h10000;
    localparam logic [KCOST_BITS-1:0] KBONUS_RESET = 40'h01_0000_0000;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TRAVERSAL_COST,
        REG_INTERSECT_COST,
        REG_EMPTY_BONUS
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [2:0] {
        CASE_BOTH,
        CASE_LEFT_EMPTY,
        CASE_RIGHT_EMPTY,
        CASE_OUTSIDE,
        CASE_DEGENERATE
    } split_case_t;

    typedef struct packed {
        axis_t       axis;
        split_case_t scase;
        logic        force_max;
    } side_t;

endpackage

`default_nettype wire

### hdl/sah_in_if.sv
// request channel of the split cost unit: box, plane and counts
// depends on sah_pkg for default widths
`default_nettype none

interface sah_in_if
    import sah_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;
    logic [1:0]                   split_axis;
    logic signed [COORD_BITS-1:0] split_position;
    logic [COUNT_BITS-1:0]        count_left;
    logic [COUNT_BITS-1:0]        count_right;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output split_axis, split_position, count_left, count_right,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  split_axis, split_position, count_left, count_right,
        output ready
    );
endinterface

`default_nettype wire

### hdl/sah_out_if.sv
// result channel of the split cost unit: cost and case code
// depends on sah_pkg for widths
`default_nettype none

interface sah_out_if
    import sah_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COST_BITS-1:0] split_cost;
    logic [2:0]           split_case;

    modport source (output valid, split_cost, split_case, input ready);
    modport sink (input valid, split_cost, split_case, output ready);
endinterface

`default_nettype wire

### hdl/sah_classify.sv
// first stage: order keys, range checks, case code, extents and plane offsets
// depends on sah_pkg
`default_nettype none

module sah_classify
    import sah_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] box_min_x,
    input  logic [COORD_BITS-1:0] box_min_y,
    input  logic [COORD_BITS-1:0] box_min_z,
    input  logic [COORD_BITS-1:0] box_max_x,
    input  logic [COORD_BITS-1:0] box_max_y,
    input  logic [COORD_BITS-1:0] box_max_z,
    input  logic [1:0]            split_axis,
    input  logic [COORD_BITS-1:0] split_position,
    input  logic [COUNT_BITS-1:0] count_left,
    input  logic [COUNT_BITS-1:0] count_right,
    output logic [COORD_BITS-1:0] dx,
    output logic [COORD_BITS-1:0] dy,
    output logic [COORD_BITS-1:0] dz,
    output logic [COORD_BITS-1:0] ta,
    output logic [COORD_BITS-1:0] tb,
    output logic [COORD_BITS:0]   p,
    output logic [COUNT_BITS:0]   m1,
    output logic [COUNT_BITS:0]   m2,
    output side_t                 side
);

    localparam logic [COORD_BITS-1:0] SIGN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz, pos;
    logic [COORD_BITS-1:0] la, ha, lu, hu, lv, hv;
    logic [COORD_BITS-1:0] du, dv;
    logic                  outside, degen, left_empty, right_empty;
    split_case_t           scase;

    logic [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg, ta_reg, tb_reg;
    logic [COORD_BITS-1:0] dx_next, dy_next, dz_next, ta_next, tb_next;
    logic [COORD_BITS:0]   p_reg, p_next;
    logic [COUNT_BITS:0]   m1_reg, m2_reg, m1_next, m2_next;
    side_t                 side_reg, side_next;

    // offset binary keys compare as unsigned
    assign lx  = box_min_x ^ SIGN;
    assign ly  = box_min_y ^ SIGN;
    assign lz  = box_min_z ^ SIGN;
    assign hx  = box_max_x ^ SIGN;
    assign hy  = box_max_y ^ SIGN;
    assign hz  = box_max_z ^ SIGN;
    assign pos = split_position ^ SIGN;

    always_comb
    begin
        case (split_axis)
            AXIS_Y:
            begin
                la = ly; ha = hy; lu = lz; hu = hz; lv = lx; hv = hx;
            end
            AXIS_Z:
            begin
                la = lz; ha = hz; lu = lx; hu = hx; lv = ly; hv = hy;
            end
            default:
            begin
                la = lx; ha = hx; lu = ly; hu = hy; lv = lz; hv = hz;
            end
        endcase
    end

    always_comb
    begin
        outside     = (split_axis > AXIS_Z) || (pos < la) || (pos > ha);
        degen       = (hu < lu) || (hv < lv);
        left_empty  = (count_left == '0) && (pos > la);
        right_empty = (count_right == '0) && (pos < ha);
        du          = hu - lu;
        dv          = hv - lv;

        if (outside)
            scase = CASE_OUTSIDE;
        else if (degen)
            scase = CASE_DEGENERATE;
        else if (left_empty)
            scase = CASE_LEFT_EMPTY;
        else if (right_empty)
            scase = CASE_RIGHT_EMPTY;
        else
            scase = CASE_BOTH;

        // cost weights: na*m1 goes with the lower child, nb*m2 with the upper
        case (scase)
            CASE_LEFT_EMPTY:
            begin
                m1_next = '0;
                m2_next = {1'b0, count_right};
            end
            CASE_RIGHT_EMPTY:
            begin
                m1_next = {1'b0, count_left} + {1'b0, count_right};
                m2_next = '0;
            end
            default:
            begin
                m1_next = {1'b0, count_left};
                m2_next = {1'b0, count_right};
            end
        endcase

        dx_next = hx - lx;
        dy_next = hy - ly;
        dz_next = hz - lz;
        ta_next = pos - la;
        tb_next = ha - pos;
        p_next  = {1'b0, du} + {1'b0, dv};

        side_next.axis      = axis_t'(split_axis);
        side_next.scase     = scase;
        side_next.force_max = outside || degen;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            dz_reg   <= dz_next;
            ta_reg   <= ta_next;
            tb_reg   <= tb_next;
            p_reg    <= p_next;
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            side_reg <= side_next;
        end
    end

    assign dx   = dx_reg;
    assign dy   = dy_reg;
    assign dz   = dz_reg;
    assign ta   = ta_reg;
    assign tb   = tb_reg;
    assign p    = p_reg;
    assign m1   = m1_reg;
    assign m2   = m2_reg;
    assign side = side_reg;

endmodule

`default_nettype wire

### hdl/sah_mul.sv
// two-stage unsigned multiplier: registered 32x32 partial products, then their sum
// depends on sah_pkg for the chunk width
`default_nettype none

module sah_mul
    import sah_pkg::*;
#(
    parameter int A_BITS = MUL_CHUNK,
    parameter int B_BITS = MUL_CHUNK
)(
    input  logic                       clk,
    input  logic                       en,
    input  logic [A_BITS-1:0]          a,
    input  logic [B_BITS-1:0]          b,
    output logic [A_BITS+B_BITS-1:0]   prod
);

    localparam int A_CH   = (A_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int B_CH   = (B_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int A_PAD  = A_CH * MUL_CHUNK;
    localparam int B_PAD  = B_CH * MUL_CHUNK;
    localparam int P_PAD  = A_PAD + B_PAD;
    localparam int P_BITS = A_BITS + B_BITS;
    localparam int PP_BITS = 2 * MUL_CHUNK;

    logic [A_PAD-1:0]   a_pad;
    logic [B_PAD-1:0]   b_pad;
    logic [PP_BITS-1:0] pp_reg  [A_CH][B_CH];
    logic [PP_BITS-1:0] pp_next [A_CH][B_CH];
    logic [P_PAD-1:0]   sum_next;
    logic [P_BITS-1:0]  prod_reg;

    assign a_pad = A_PAD'(a);
    assign b_pad = B_PAD'(b);

    always_comb
    begin
        for (int i = 0; i < A_CH; i++)
        begin
            for (int j = 0; j < B_CH; j++)
            begin
                pp_next[i][j] = PP_BITS'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                              * PP_BITS'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < A_CH; i++)
        begin
            for (int j = 0; j < B_CH; j++)
            begin
                sum_next = sum_next + (P_PAD'(pp_reg[i][j]) << (MUL_CHUNK * (i + j)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            prod_reg <= P_BITS'(sum_next);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### hdl/sah_div.sv
// pipelined restoring divider, one quotient bit per stage
// the numerator's bits above the quotient width must form a value below the divisor
// depends on sah_pkg for side_t
`default_nettype none

module sah_div
    import sah_pkg::*;
#(
    parameter int N_BITS = 128,
    parameter int D_BITS = 66,
    parameter int Q_BITS = 61
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [N_BITS-1:0] n,
    input  logic [D_BITS-1:0] d,
    input  side_t             in_side,
    output logic              out_vld,
    output logic [Q_BITS-1:0] q,
    output side_t             out_side
);

    logic [D_BITS-1:0] rem_reg  [Q_BITS];
    logic [D_BITS-1:0] rem_next [Q_BITS];
    logic [Q_BITS-1:0] low_reg  [Q_BITS];
    logic [Q_BITS-1:0] low_next [Q_BITS];
    logic [Q_BITS-1:0] quo_reg  [Q_BITS];
    logic [Q_BITS-1:0] quo_next [Q_BITS];
    logic [D_BITS-1:0] d_reg    [Q_BITS];
    logic [D_BITS-1:0] d_next   [Q_BITS];
    side_t             side_reg [Q_BITS];
    side_t             side_next[Q_BITS];
    logic              vld_reg  [Q_BITS];
    logic              vld_next [Q_BITS];

    always_comb
    begin
        logic [D_BITS-1:0] rem_in;
        logic [Q_BITS-1:0] low_in;
        logic [Q_BITS-1:0] quo_in;
        logic [D_BITS:0]   trial;
        logic [D_BITS:0]   diff;
        logic              ge;
        for (int k = 0; k < Q_BITS; k++)
        begin
            if (k == 0)
            begin
                rem_in       = D_BITS'(n >> Q_BITS);
                low_in       = n[Q_BITS-1:0];
                quo_in       = '0;
                d_next[k]    = d;
                side_next[k] = in_side;
                vld_next[k]  = in_vld;
            end
            else
            begin
                rem_in       = rem_reg[k-1];
                low_in       = low_reg[k-1];
                quo_in       = quo_reg[k-1];
                d_next[k]    = d_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            // bring down the next numerator bit and try the subtract
            trial       = {rem_in, low_in[Q_BITS-1]};
            diff        = trial - {1'b0, d_next[k]};
            ge          = trial >= {1'b0, d_next[k]};
            rem_next[k] = ge ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
            low_next[k] = low_in << 1;
            quo_next[k] = {quo_in[Q_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_BITS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                quo_reg[k]  <= quo_next[k];
                d_reg[k]    <= d_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_BITS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < Q_BITS; k++)
                vld_reg[k] <= vld_next[k];
        end
    end

    assign out_vld  = vld_reg[Q_BITS-1];
    assign q        = quo_reg[Q_BITS-1];
    assign out_side = side_reg[Q_BITS-1];

endmodule

`default_nettype wire

### hdl/sah_split_cost_unit.sv
// throughput: one request per cycle while the pipe is not stalled;
// the quotient stages of the divider set the depth
// a stalled result holds the pipe, an empty slot at its end is still filled behind it
// reset: asynchronous active low; clears valid bits and loads the register defaults
// depends on sah_pkg, sah_in_if, sah_out_if, sah_classify, sah_mul, sah_div
`default_nettype none

module sah_split_cost_unit
    import sah_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    sah_in_if.sink                    req,
    sah_out_if.source                 rsp
);

    localparam int SW   = 2 * COORD_BITS + 2;
    localparam int TPW  = 2 * COORD_BITS + 1;
    localparam int MW   = COUNT_BITS + 1;
    localparam int WW   = SW + MW;
    localparam int NW   = WW + KCOST_BITS;
    localparam int QW   = COUNT_BITS + 41;
    localparam int QIW  = QW - FRAC_BITS;
    localparam int SUMW = (QIW + 1 > COST_BITS + 1) ? QIW + 1 : COST_BITS + 1;
    localparam int PRE  = 9;

    // configuration
    logic [TRAV_BITS-1:0]  trav_reg;
    logic [ICOST_BITS-1:0] icost_reg;
    logic [BONUS_BITS-1:0] bonus_reg;
    logic [KCOST_BITS-1:0] kbonus_reg, kbonus_next;
    logic [BONUS_BITS-1:0] bonus_clamped;
    logic [KCOST_BITS-1:0] kfull;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trav_reg   <= TRAV_RESET;
            icost_reg  <= ICOST_RESET;
            bonus_reg  <= BONUS_RESET;
            kbonus_reg <= KBONUS_RESET;
        end
        else
        begin
            kbonus_reg <= kbonus_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRAVERSAL_COST: trav_reg  <= cfg_data[TRAV_BITS-1:0];
                    REG_INTERSECT_COST: icost_reg <= cfg_data[ICOST_BITS-1:0];
                    REG_EMPTY_BONUS:    bonus_reg <= cfg_data[BONUS_BITS-1:0];
                    default:            ;
                endcase
            end
        end
    end

    assign bonus_clamped = (bonus_reg > BONUS_ONE) ? BONUS_ONE : bonus_reg;
    assign kbonus_next   = KCOST_BITS'(icost_reg) * KCOST_BITS'(BONUS_ONE - bonus_clamped);
    assign kfull         = {icost_reg, {FRAC_BITS{1'b0}}};

    // pipe control
    logic              adv;
    logic              out_load;
    logic              vld_reg [PRE];
    logic              div_vld;
    logic [QW-1:0]     div_q;
    side_t             div_side;
    logic              out_valid_reg;
    logic [COST_BITS-1:0] out_cost_reg, out_cost_next;
    split_case_t       out_case_reg;

    assign out_load  = !out_valid_reg || rsp.ready;
    assign adv       = out_load || !div_vld;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PRE; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
            for (int k = 1; k < PRE; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 0
    logic [COORD_BITS-1:0] cls_dx, cls_dy, cls_dz, cls_ta, cls_tb;
    logic [COORD_BITS:0]   cls_p;
    logic [MW-1:0]         cls_m1, cls_m2;
    side_t                 cls_side;

    sah_classify #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_classify (
        .clk            (clk),
        .en             (adv),
        .box_min_x      (req.box_min_x),
        .box_min_y      (req.box_min_y),
        .box_min_z      (req.box_min_z),
        .box_max_x      (req.box_max_x),
        .box_max_y      (req.box_max_y),
        .box_max_z      (req.box_max_z),
        .split_axis     (req.split_axis),
        .split_position (req.split_position),
        .count_left     (req.count_left),
        .count_right    (req.count_right),
        .dx             (cls_dx),
        .dy             (cls_dy),
        .dz             (cls_dz),
        .ta             (cls_ta),
        .tb             (cls_tb),
        .p              (cls_p),
        .m1             (cls_m1),
        .m2             (cls_m2),
        .side           (cls_side)
    );

    // stages 1-2: face products and offset products
    logic [2*COORD_BITS-1:0] dxy, dyz, dzx;
    logic [TPW-1:0]          tap, tbp;

    sah_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS)) u_mul_xy
        (.clk(clk), .en(adv), .a(cls_dx), .b(cls_dy), .prod(dxy));
    sah_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS)) u_mul_yz
        (.clk(clk), .en(adv), .a(cls_dy), .b(cls_dz), .prod(dyz));
    sah_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS)) u_mul_zx
        (.clk(clk), .en(adv), .a(cls_dz), .b(cls_dx), .prod(dzx));
    sah_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS + 1)) u_mul_ta
        (.clk(clk), .en(adv), .a(cls_ta), .b(cls_p), .prod(tap));
    sah_mul #(.A_BITS(COORD_BITS), .B_BITS(COORD_BITS + 1)) u_mul_tb
        (.clk(clk), .en(adv), .a(cls_tb), .b(cls_p), .prod(tbp));

    // sideband delay lines
    side_t         side_pipe [1:8];
    side_t         side_chk;
    logic [MW-1:0] m1_pipe [1:3];
    logic [MW-1:0] m2_pipe [1:3];
    logic [SW-1:0] s_pipe  [3:8];
    logic [SW-1:0] na_reg, nb_reg, s_next, na_next, nb_next;
    logic [2*COORD_BITS-1:0] c_sel;
    logic [WW-1:0] wa, wb, w_reg;
    logic [KCOST_BITS-1:0] k_sel;
    logic [NW-1:0] num;

    // stage 3: total area, child areas
    always_comb
    begin
        case (side_pipe[2].axis)
            AXIS_Y:  c_sel = dzx;
            AXIS_Z:  c_sel = dxy;
            default: c_sel = dyz;
        endcase
        s_next  = SW'(dxy) + SW'(dyz) + SW'(dzx);
        na_next = SW'(c_sel) + SW'(tap);
        nb_next = SW'(c_sel) + SW'(tbp);
    end

    // zero total area is a degenerate box
    always_comb
    begin
        side_chk = side_pipe[5];
        if (!side_pipe[5].force_max && (s_pipe[5] == '0))
        begin
            side_chk.scase     = CASE_DEGENERATE;
            side_chk.force_max = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_pipe[1] <= cls_side;
            for (int k = 2; k <= 5; k++)
                side_pipe[k] <= side_pipe[k-1];
            side_pipe[6] <= side_chk;
            side_pipe[7] <= side_pipe[6];
            side_pipe[8] <= side_pipe[7];

            m1_pipe[1] <= cls_m1;
            m2_pipe[1] <= cls_m2;
            for (int k = 2; k <= 3; k++)
            begin
                m1_pipe[k] <= m1_pipe[k-1];
                m2_pipe[k] <= m2_pipe[k-1];
            end

            s_pipe[3] <= s_next;
            for (int k = 4; k <= 8; k++)
                s_pipe[k] <= s_pipe[k-1];
            na_reg <= na_next;
            nb_reg <= nb_next;

            w_reg <= wa + wb;
        end
    end

    // stages 4-5: weighted child areas
    sah_mul #(.A_BITS(SW), .B_BITS(MW)) u_mul_wa
        (.clk(clk), .en(adv), .a(na_reg), .b(m1_pipe[3]), .prod(wa));
    sah_mul #(.A_BITS(SW), .B_BITS(MW)) u_mul_wb
        (.clk(clk), .en(adv), .a(nb_reg), .b(m2_pipe[3]), .prod(wb));

    // stages 7-8: scale by intersection cost and the empty side factor
    assign k_sel = (side_pipe[6].scase == CASE_BOTH) ? kfull : kbonus_reg;

    sah_mul #(.A_BITS(WW), .B_BITS(KCOST_BITS)) u_mul_k
        (.clk(clk), .en(adv), .a(w_reg), .b(k_sel), .prod(num));

    // divide by the node area
    sah_div #(
        .N_BITS (NW),
        .D_BITS (SW),
        .Q_BITS (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (vld_reg[PRE-1]),
        .n        (num),
        .d        (s_pipe[8]),
        .in_side  (side_pipe[8]),
        .out_vld  (div_vld),
        .q        (div_q),
        .out_side (div_side)
    );

    // add traversal cost, saturate
    logic [SUMW-1:0] cost_sum;

    always_comb
    begin
        cost_sum = SUMW'(div_q[QW-1:FRAC_BITS]) + SUMW'(trav_reg);
        if (div_side.force_max || (cost_sum[SUMW-1:COST_BITS] != '0))
            out_cost_next = '1;
        else
            out_cost_next = cost_sum[COST_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= div_vld;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && div_vld)
        begin
            out_cost_reg <= out_cost_next;
            out_case_reg <= div_side.scase;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.split_cost = out_cost_reg;
    assign rsp.split_case = out_case_reg;

`ifndef SYNTHESIS
    a_force_max_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_case_reg == CASE_OUTSIDE || out_case_reg == CASE_DEGENERATE)
        |-> out_cost_reg == '1)
        else $error("outside or degenerate result without full scale cost");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> out_valid_reg && !rsp.ready && div_vld)
        else $error("pipe held without a blocked result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        div_vld && out_load |=> out_valid_reg)
        else $error("finished request not moved into the output register");
`endif

endmodule

`default_nettype wire
